// ===== src/rsbk_pkg.sv =====
// Shared constants and record layout for the record sorter.
`default_nettype none
package rsbk_pkg;
  localparam int MAX_RECORDS = 32;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  localparam int ROLL_W = 11;
  localparam int AGE_W  = 5;
  localparam int MARK_W = 7;
  localparam int REC_W  = ROLL_W + AGE_W + MARK_W;
  localparam int DATA_W = ((REC_W + 7) / 8) * 8;

  typedef logic [REC_W-1:0] rec_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // key sits in the low bits, same packing as the stream data
  function automatic logic [ROLL_W-1:0] key_of(rec_t r);
    return r[ROLL_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== src/rsbk_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none
module rsbk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== src/record_sort_by_key.sv =====
// Top level of the record sorter: load, in-place exchange sort in RAM, emit.
//  Flow: records load at one per cycle while in S_LOAD; after the last
//  request the sort runs one RAM compare per cycle, pausing to write back
//  each minimum, then each record is read, loaded into the output register
//  and held until taken. Throughput per set is set by the single read and
//  single write port of the record RAM. Reset: clears state, count, indices
//  and output flags, not the RAM; only entries below the count are ever used.
`default_nettype none
module record_sort_by_key (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // [10:0] key_roll, [15:11] age_value, [22:16] mark_value, [23] zero
  input  wire logic [rsbk_pkg::DATA_W-1:0] s_axis_tdata,
  input  wire logic                       s_axis_tlast,   // last_in
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [10:0] out_roll, [15:11] out_age, [22:16] out_mark, [23] zero
  output logic      [rsbk_pkg::DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast    // last_out
);
  import rsbk_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,   // taking records
    S_RDA,    // start of sort: read entry a
    S_RDB,    // capture entry a into cur, read entry b
    S_CMP,    // compare cur with entry b, swap, read next b
    S_WRA,    // write back the minimum at a, read next a
    S_ERD,    // emit: read entry k
    S_ELD,    // emit: load output register
    S_EOUT    // emit: hold until taken
  } state_t;

  state_t state;
  cnt_t   count;   // records held
  idx_t   a;       // outer index, reused as emit index
  idx_t   b;       // inner index
  rec_t   cur;     // running minimum for position a
  rec_t   out_rec;

  logic   wr_en;
  idx_t   wr_addr;
  rec_t   wr_data;
  idx_t   rd_addr;
  rec_t   rd_data;

  logic   in_req;
  logic   full;
  cnt_t   count_next;
  logic   swap;
  logic   b_end;
  logic   a_end;
  logic   k_end;

  assign in_req     = s_axis_tvalid && s_axis_tready;
  assign full       = (count == cnt_t'(MAX_RECORDS));
  assign count_next = full ? count : count + cnt_t'(1);
  assign swap       = key_of(cur) > key_of(rd_data);
  assign b_end      = ({1'b0, b} == count - cnt_t'(1));
  assign a_end      = ({1'b0, a} + cnt_t'(2) == count);
  assign k_end      = ({1'b0, a} + cnt_t'(1) == count);

  assign s_axis_tready = (state == S_LOAD);
  assign m_axis_tdata  = {{(DATA_W-REC_W){1'b0}}, out_rec};

  // RAM port steering
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = b;
    wr_data = cur;
    rd_addr = a;
    unique case (state)
      S_LOAD: begin
        wr_en   = in_req && !full;
        wr_addr = count[IDX_W-1:0];
        wr_data = s_axis_tdata[REC_W-1:0];
      end
      S_RDA:  rd_addr = a;
      S_RDB:  rd_addr = b;
      S_CMP: begin
        wr_en   = swap;
        wr_addr = b;
        rd_addr = b + idx_t'(1);
      end
      S_WRA: begin
        wr_en   = 1'b1;
        wr_addr = a;
        rd_addr = a + idx_t'(1);
      end
      S_ERD:  rd_addr = a;
      S_ELD:  rd_addr = a;
      S_EOUT: rd_addr = a;
      default: rd_addr = a;
    endcase
  end

  rsbk_ram #(
    .WIDTH(REC_W),
    .DEPTH(MAX_RECORDS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      a             <= '0;
      b             <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_req) begin
            count <= count_next;
            a     <= '0;
            b     <= idx_t'(1);
            if (s_axis_tlast) begin
              // a single record needs no sorting
              state <= (count_next > cnt_t'(1)) ? S_RDA : S_ERD;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          cur   <= rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          if (swap) begin
            cur <= rd_data;
          end
          if (b_end) begin
            state <= S_WRA;
          end else begin
            b <= b + idx_t'(1);
          end
        end
        S_WRA: begin
          if (a_end) begin
            a     <= '0;
            state <= S_ERD;
          end else begin
            a     <= a + idx_t'(1);
            b     <= a + idx_t'(2);
            state <= S_RDB;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          out_rec       <= rd_data;
          m_axis_tvalid <= 1'b1;
          m_axis_tlast  <= k_end;
          state         <= S_EOUT;
        end
        S_EOUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (k_end) begin
              count <= '0;
              a     <= '0;
              state <= S_LOAD;
            end else begin
              a     <= a + idx_t'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output only shows up while holding a result
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_EOUT))
    else $error("output valid outside emit hold");

  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // inner index always lies past the outer index during compares
  a_b_after_a: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (b > a))
    else $error("inner index not past outer index");

  // record count never exceeds the store
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(MAX_RECORDS))
    else $error("record count overflow");

  // a last request closes the input until the set is emitted
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (in_req && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after last request");
endmodule
`default_nettype wire
